@@ rtl/core/servo_command_rate_guard_assert.svh @@
// ----------------------------------------------------------------------------
// servo_command_rate_guard assertion macros
// Concurrent assertion wrappers on clk; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SERVO_COMMAND_RATE_GUARD_ASSERT_SVH
`define SERVO_COMMAND_RATE_GUARD_ASSERT_SVH

`ifndef SYNTH
// check on every clock edge outside reset
`define SCRG_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scrg assertion failed");
// check on every clock edge, reset included
`define SCRG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scrg assertion failed");
`else
`define SCRG_ASSERT(label, prop)
`define SCRG_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ rtl/core/scrg_pkg.sv @@
// ----------------------------------------------------------------------------
// scrg_pkg
// Shared types, constants and the pulse level function of the servo guard.
// ----------------------------------------------------------------------------
package scrg_pkg;

  localparam int unsigned SERVO_COUNT = 2;
  localparam int unsigned SERVO_IDX_W = 1;

  localparam logic [11:0] LEVEL_BASE  = 12'd500;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;
  localparam logic [7:0]  ANGLE_SCALE = 8'd100;
  // floor(x/9) == (x*58255) >> 19 for every x up to 180*100
  localparam logic [15:0] DIV9_RECIP  = 16'd58255;
  localparam int unsigned DIV9_SHIFT  = 19;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_SKIP  = 2'd1,
    ST_BLOCK = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_MIN_INTERVAL  = 2'd0,
    REG_WINDOW_LENGTH = 2'd1,
    REG_WINDOW_LIMIT  = 2'd2,
    REG_COOLDOWN      = 2'd3
  } reg_addr_t;

  typedef struct packed {
    logic [15:0] min_interval_ms;
    logic [15:0] window_length_ms;
    logic [7:0]  window_limit;
    logic [15:0] cooldown_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    min_interval_ms:  16'd250,
    window_length_ms: 16'd1200,
    window_limit:     8'd5,
    cooldown_ms:      16'd2000
  };

  typedef struct packed {
    status_t     status;
    logic [11:0] pulse_level;
    logic        lockout_tripped;
  } result_t;

  function automatic logic [11:0] level_of(logic [7:0] angle);
    logic [7:0]  a;
    logic [14:0] scaled;
    logic [30:0] prod;
    a      = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
    scaled = 15'(a * ANGLE_SCALE);
    prod   = 31'(scaled * DIV9_RECIP);
    return LEVEL_BASE + 12'(prod >> DIV9_SHIFT);
  endfunction

endpackage

@@ rtl/core/scrg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// scrg_cfg_regs
// APB register file holding the guard limits; zero wait states.
// ----------------------------------------------------------------------------
module scrg_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output scrg_pkg::cfg_t cfg
);
  import scrg_pkg::*;

  logic      wr_en;
  reg_addr_t addr;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign addr   = reg_addr_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (addr)
        REG_MIN_INTERVAL:  cfg.min_interval_ms  <= pwdata[15:0];
        REG_WINDOW_LENGTH: cfg.window_length_ms <= pwdata[15:0];
        REG_WINDOW_LIMIT:  cfg.window_limit     <= pwdata[7:0];
        REG_COOLDOWN:      cfg.cooldown_ms      <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (addr)
      REG_MIN_INTERVAL:  prdata = {16'd0, cfg.min_interval_ms};
      REG_WINDOW_LENGTH: prdata = {16'd0, cfg.window_length_ms};
      REG_WINDOW_LIMIT:  prdata = {24'd0, cfg.window_limit};
      REG_COOLDOWN:      prdata = {16'd0, cfg.cooldown_ms};
    endcase
  end

`include "servo_command_rate_guard_assert.svh"

  `SCRG_ASSERT(a_limit_write, wr_en && addr == REG_WINDOW_LIMIT |=> cfg.window_limit == $past(pwdata[7:0]))

endmodule

@@ rtl/core/scrg_guard_core.sv @@
// ----------------------------------------------------------------------------
// scrg_guard_core
// Per-servo guard state and the single-pass check of one command.
// ----------------------------------------------------------------------------
module scrg_guard_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step_en,
  input  logic [scrg_pkg::SERVO_IDX_W-1:0]  servo_index,
  input  logic [31:0]                       now_ms,
  input  logic [7:0]                        cmd_angle,
  input  scrg_pkg::cfg_t                    cfg,
  output scrg_pkg::result_t                 result
);
  import scrg_pkg::*;

  // per-servo state
  logic        guard_ready      [SERVO_COUNT];
  logic [7:0]  current_angle    [SERVO_COUNT];
  logic [11:0] current_level    [SERVO_COUNT];
  logic        last_time_valid  [SERVO_COUNT];
  logic [31:0] last_accept_time [SERVO_COUNT];
  logic [31:0] window_start     [SERVO_COUNT];
  logic [31:0] lockout_end      [SERVO_COUNT];
  logic [7:0]  window_count     [SERVO_COUNT];

  // next values for the addressed servo
  logic        in_range;
  logic [7:0]  angle_next;
  logic [11:0] level_next;
  logic        last_valid_next;
  logic [31:0] last_time_next;
  logic [31:0] win_start_next;
  logic [31:0] lock_end_next;
  logic [7:0]  count_next;

  logic [11:0] target_level;

  assign in_range     = 32'(servo_index) < SERVO_COUNT;
  assign target_level = level_of(cmd_angle);

  always_comb begin
    logic        ready;
    logic [7:0]  cur_angle;
    logic [11:0] cur_level;
    logic        last_v;
    logic [31:0] win_eff;
    logic [31:0] lock_eff;
    logic [7:0]  count_eff;
    logic [31:0] d_lock;
    logic [31:0] d_last;
    logic [31:0] d_win;
    logic        locked;
    logic        too_soon;
    logic        restart;
    logic [7:0]  count_base;
    logic [7:0]  count_inc;

    ready     = guard_ready[servo_index];
    // a servo seen for the first time starts from a fresh guard
    cur_angle = ready ? current_angle[servo_index]   : 8'd0;
    cur_level = ready ? current_level[servo_index]   : LEVEL_BASE;
    last_v    = ready ? last_time_valid[servo_index] : 1'b0;
    win_eff   = ready ? window_start[servo_index]    : now_ms;
    lock_eff  = ready ? lockout_end[servo_index]     : now_ms;
    count_eff = ready ? window_count[servo_index]    : 8'd0;

    d_lock   = lock_eff - now_ms;
    d_last   = now_ms - last_accept_time[servo_index];
    d_win    = now_ms - win_eff;
    locked   = (d_lock != 32'd0) && !d_lock[31];
    too_soon = last_v && (d_last[31] || d_last < {16'd0, cfg.min_interval_ms});
    restart  = !d_win[31] && (d_win > {16'd0, cfg.window_length_ms});

    count_base = restart ? 8'd0 : count_eff;
    count_inc  = (count_base == COUNT_MAX) ? COUNT_MAX : count_base + 8'd1;

    angle_next      = cur_angle;
    level_next      = cur_level;
    last_valid_next = last_v;
    last_time_next  = last_accept_time[servo_index];
    win_start_next  = win_eff;
    lock_end_next   = lock_eff;
    count_next      = count_eff;

    result.status          = ST_BLOCK;
    result.pulse_level     = cur_level;
    result.lockout_tripped = 1'b0;

    if (!in_range) begin
      result.pulse_level = LEVEL_BASE;
    end else if (locked) begin
      result.status = ST_BLOCK;
    end else if (cmd_angle == cur_angle) begin
      result.status = ST_SKIP;
    end else if (too_soon) begin
      result.status = ST_BLOCK;
    end else begin
      win_start_next = restart ? now_ms : win_eff;
      count_next     = count_inc;
      if ({24'd0, count_inc} > {24'd0, cfg.window_limit}) begin
        // over the window limit: start the cooldown
        lock_end_next          = now_ms + {16'd0, cfg.cooldown_ms};
        result.status          = ST_BLOCK;
        result.lockout_tripped = 1'b1;
      end else begin
        angle_next         = cmd_angle;
        level_next         = target_level;
        last_valid_next    = 1'b1;
        last_time_next     = now_ms;
        result.status      = ST_DONE;
        result.pulse_level = target_level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        guard_ready[i]     <= 1'b0;
        last_time_valid[i] <= 1'b0;
      end
    end else if (step_en && in_range) begin
      guard_ready[servo_index]     <= 1'b1;
      last_time_valid[servo_index] <= last_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && in_range) begin
      current_angle[servo_index]    <= angle_next;
      current_level[servo_index]    <= level_next;
      last_accept_time[servo_index] <= last_time_next;
      window_start[servo_index]     <= win_start_next;
      lockout_end[servo_index]      <= lock_end_next;
      window_count[servo_index]     <= count_next;
    end
  end

`include "servo_command_rate_guard_assert.svh"

  `SCRG_ASSERT(a_trip_blocks, result.lockout_tripped |-> result.status == ST_BLOCK)
  `SCRG_ASSERT(a_ready_sticks, $past(guard_ready[0]) |-> guard_ready[0])
  `SCRG_ASSERT(a_valid_needs_ready, last_time_valid[0] |-> guard_ready[0])

endmodule

@@ rtl/core/servo_command_rate_guard.sv @@
// ----------------------------------------------------------------------------
// servo_command_rate_guard
// Rate limiter with lockout for servo angle commands; top level.
// ----------------------------------------------------------------------------
// Commands arrive on the s_ stream: s_tuser selects the servo, s_tdata
// carries the millisecond timestamp and the requested angle. Each command
// gives exactly one result beat on the m_ stream: status (done, skipped,
// blocked), the servo's PWM compare level after the command, and a flag
// set when the command tripped a cooldown lockout.
// A command passes through the input register, then the guard check and
// state update into the result register.
// Throughput is one command per cycle while m_tready stays high; the
// per-servo state is written in the same cycle the result is registered,
// so back-to-back commands to the same servo see each other's updates.
// When m_tready is low and a result is held, one more command may sit in
// the input register; s_tready then drops until the result is taken.
// Reset clears all guards (each servo is set up again on its next command)
// and loads the default limits. The user must write the limits through the
// APB port only while the stream is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module servo_command_rate_guard (
  input  logic        clk,
  input  logic        rst,
  // command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] now_ms, [39:32] angle
  input  logic        s_tuser,   // [0] servo_index
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] status, [13:2] pulse_level,
                                 // [14] lockout_tripped, [15] zero
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import scrg_pkg::*;

  cfg_t cfg;

  logic                   in_valid;
  logic [SERVO_IDX_W-1:0] in_index;
  logic [31:0]            in_now;
  logic [7:0]             in_angle;
  logic                   advance;

  result_t step_result;
  result_t out_result;

  scrg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scrg_guard_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (advance),
    .servo_index  (in_index),
    .now_ms       (in_now),
    .cmd_angle    (in_angle),
    .cfg          (cfg),
    .result       (step_result)
  );

  // move the held command into the result register when it is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_index <= SERVO_IDX_W'(s_tuser);
      in_now   <= s_tdata[31:0];
      in_angle <= s_tdata[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign m_tdata = {1'b0, out_result.lockout_tripped, out_result.pulse_level,
                    out_result.status};

`include "servo_command_rate_guard_assert.svh"

  `SCRG_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && !in_valid)
  `SCRG_ASSERT(a_advance_fills, advance |=> m_tvalid)

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// servo_command_rate_guard testbench
// Drives angle commands into the guard, predicts status, pulse level and
// lockout for every accepted beat, and checks each result beat in order.
// Covers register access, the guard rules, limit extremes, window count
// saturation, random traffic with idle and stall patterns, and backpressure.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scrg_pkg::*;

  localparam int unsigned ANGLE_CLAMP = 180;
  localparam int unsigned PULSE_BASE  = 500;
  localparam logic [7:0]  HITS_SAT    = 8'hFF;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;   // [31:0] now_ms, [39:32] angle
  logic        s_tuser  = 1'b0; // [0] servo_index
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] status, [13:2] pulse_level, [14] lockout_tripped
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [3:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_command_rate_guard dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // guard limits and per-servo guard state as the predictor sees them
  cfg_t        guard_cfg = '{16'd250, 16'd1200, 8'd5, 16'd2000};
  bit          guard_ready [SERVO_COUNT];
  logic [7:0]  servo_angle [SERVO_COUNT];
  bit          stamp_valid [SERVO_COUNT];
  logic [31:0] accept_ms   [SERVO_COUNT];
  logic [31:0] window_ms   [SERVO_COUNT];
  logic [31:0] lockout_ms  [SERVO_COUNT];
  logic [7:0]  window_hits [SERVO_COUNT];

  result_t     pending_results [$];
  int          err_count     = 0;
  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  int          stall_left    = 0;
  logic [31:0] traffic_ms    = '0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("servo_command_rate_guard verification failed");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // signed modulo-2^32 time differences
  function automatic bit ahead_of(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d != 0 && !d[31];
  endfunction

  function automatic bit earlier_than(logic [31:0] a, logic [31:0] b, logic [31:0] bound);
    logic [31:0] d;
    d = a - b;
    return d[31] || d < bound;
  endfunction

  function automatic bit later_than(logic [31:0] a, logic [31:0] b, logic [31:0] bound);
    logic [31:0] d;
    d = a - b;
    return !d[31] && d > bound;
  endfunction

  function automatic result_t guard_step(bit idx, logic [31:0] now, logic [7:0] angle);
    result_t     r;
    int unsigned capped;
    r.lockout_tripped = 1'b0;
    if (!guard_ready[idx]) begin
      servo_angle[idx] = '0;
      stamp_valid[idx] = 1'b0;
      window_ms[idx]   = now;
      lockout_ms[idx]  = now;
      window_hits[idx] = '0;
      guard_ready[idx] = 1'b1;
    end
    if (ahead_of(lockout_ms[idx], now)) begin
      r.status = ST_BLOCK;
    end else if (angle == servo_angle[idx]) begin
      r.status = ST_SKIP;
    end else if (stamp_valid[idx] &&
                 earlier_than(now, accept_ms[idx], 32'(guard_cfg.min_interval_ms))) begin
      r.status = ST_BLOCK;
    end else begin
      if (later_than(now, window_ms[idx], 32'(guard_cfg.window_length_ms))) begin
        window_ms[idx]   = now;
        window_hits[idx] = '0;
      end
      if (window_hits[idx] != HITS_SAT) window_hits[idx]++;
      if (window_hits[idx] > guard_cfg.window_limit) begin
        lockout_ms[idx]   = now + 32'(guard_cfg.cooldown_ms);
        r.status          = ST_BLOCK;
        r.lockout_tripped = 1'b1;
      end else begin
        servo_angle[idx] = angle;
        accept_ms[idx]   = now;
        stamp_valid[idx] = 1'b1;
        r.status         = ST_DONE;
      end
    end
    capped        = (servo_angle[idx] > ANGLE_CLAMP) ? ANGLE_CLAMP : servo_angle[idx];
    r.pulse_level = 12'(PULSE_BASE + (capped * 100) / 9);
    return r;
  endfunction

  task automatic apb_write(reg_addr_t r, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_MIN_INTERVAL:  guard_cfg.min_interval_ms  = value[15:0];
      REG_WINDOW_LENGTH: guard_cfg.window_length_ms = value[15:0];
      REG_WINDOW_LIMIT:  guard_cfg.window_limit     = value[7:0];
      REG_COOLDOWN:      guard_cfg.cooldown_ms      = value[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic check_register(reg_addr_t r);
    logic [31:0] got;
    logic [31:0] want;
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got     = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_MIN_INTERVAL:  want = 32'(guard_cfg.min_interval_ms);
      REG_WINDOW_LENGTH: want = 32'(guard_cfg.window_length_ms);
      REG_WINDOW_LIMIT:  want = 32'(guard_cfg.window_limit);
      default:           want = 32'(guard_cfg.cooldown_ms);
    endcase
    if (got !== want) report_mismatch($sformatf("register %s readback", r.name()), got, want);
    @(posedge clk);
  endtask

  task automatic configure(int unsigned min_ms, int unsigned win_ms, int unsigned lim,
                           int unsigned cool_ms);
    apb_write(REG_MIN_INTERVAL, min_ms);
    apb_write(REG_WINDOW_LENGTH, win_ms);
    apb_write(REG_WINDOW_LIMIT, lim);
    apb_write(REG_COOLDOWN, cool_ms);
    check_register(REG_MIN_INTERVAL);
    check_register(REG_WINDOW_LENGTH);
    check_register(REG_WINDOW_LIMIT);
    check_register(REG_COOLDOWN);
  endtask

  // offer one command beat, hold it until taken, then record its expected result
  task automatic issue_command(bit idx, logic [31:0] now, logic [7:0] angle);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {angle, now};
    s_tuser  <= idx;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(guard_step(idx, now, angle));
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mostly forward-moving time with steps sized against the current limits
  task automatic random_commands(int count);
    bit          idx;
    logic [31:0] now;
    logic [7:0]  angle;
    int          pick;
    for (int i = 0; i < count; i++) begin
      idx = 1'($urandom_range(1));
      if ($urandom_range(99) < 8) begin
        now = $urandom();
      end else begin
        case ($urandom_range(5))
          0: traffic_ms += 0;
          1: traffic_ms += $urandom_range(guard_cfg.min_interval_ms);
          2: traffic_ms += guard_cfg.min_interval_ms + $urandom_range(20);
          3: traffic_ms += $urandom_range(2 * guard_cfg.window_length_ms + 1);
          4: traffic_ms += guard_cfg.cooldown_ms + $urandom_range(50);
          default: traffic_ms += $urandom_range(3);
        endcase
        now = traffic_ms;
      end
      pick = $urandom_range(9);
      if (pick < 2) angle = servo_angle[idx];
      else if (pick < 4) angle = 8'($urandom_range(181, 255));
      else angle = 8'($urandom_range(180));
      issue_command(idx, now, angle);
    end
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= (rcv_stall_pct == 0) || ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.status)
          report_mismatch("status", m_tdata[1:0], want.status);
        if (m_tdata[13:2] !== want.pulse_level)
          report_mismatch("pulse_level", m_tdata[13:2], want.pulse_level);
        if (m_tdata[14] !== want.lockout_tripped)
          report_mismatch("lockout_tripped", m_tdata[14], want.lockout_tripped);
      end
    end
  end

  task automatic test_register_access();
    check_register(REG_MIN_INTERVAL);
    check_register(REG_WINDOW_LENGTH);
    check_register(REG_WINDOW_LIMIT);
    check_register(REG_COOLDOWN);
    configure($urandom_range(65535), $urandom_range(1, 65535), $urandom_range(1, 254),
              $urandom_range(65535));
    configure(250, 1200, 5, 2000);
  endtask

  task automatic test_guard_rules();
    issue_command(0, 32'd1000, 8'd0);     // first use, same angle as the fresh guard
    issue_command(0, 32'd1000, 8'd90);
    issue_command(0, 32'd1100, 8'd45);    // too soon
    issue_command(0, 32'd1100, 8'd90);    // same angle wins over too soon
    issue_command(0, 32'd1400, 8'd255);   // clamped pulse level
    issue_command(0, 32'd1650, 8'd181);
    issue_command(0, 32'd1900, 8'd180);
    issue_command(0, 32'd2150, 8'd1);
    issue_command(0, 32'd2199, 8'd2);
    issue_command(0, 32'd1500, 8'd77);    // time runs backward
    issue_command(0, 32'd2500, 8'd3);     // window restart
    issue_command(1, 32'hFFFF_FF00, 8'd10);
    issue_command(1, 32'h0000_0010, 8'd20); // wraps past zero
    issue_command(1, 32'hFFFF_FFFF, 8'd21);
    issue_command(1, 32'h9000_0020, 8'd30); // half-range jump looks like a running cooldown
    wait_results_drained();
    // tight limits: trip, block during cooldown, stay over the limit until the window restarts
    configure(10, 1000, 2, 300);
    issue_command(0, 32'd10000, 8'd10);
    issue_command(0, 32'd10020, 8'd20);
    issue_command(0, 32'd10040, 8'd30);
    issue_command(0, 32'd10050, 8'd40);
    issue_command(0, 32'd10400, 8'd50);
    issue_command(0, 32'd10800, 8'd55);
    issue_command(0, 32'd11200, 8'd60);
    issue_command(0, 32'd11220, 8'd65);
    wait_results_drained();
  endtask

  task automatic test_limit_extremes();
    // zero cooldown; these stamps still fall inside servo 1's wrapped lockout, so all are blocked
    configure(0, 1, 1, 0);
    issue_command(1, 32'h9000_5000, 8'd100);
    issue_command(1, 32'h9000_5000, 8'd101);
    issue_command(1, 32'h9000_5000, 8'd102);
    issue_command(1, 32'h9000_5002, 8'd103);
    issue_command(1, 32'h9000_5002, 8'd104);
    wait_results_drained();
    // zero window limit; both servos are still locked out at these stamps, so every command is blocked
    configure(0, 1, 0, 0);
    issue_command(1, 32'h9000_5010, 8'd1);
    issue_command(1, 32'h9000_5020, 8'd2);
    issue_command(0, 32'h9000_5020, 8'd3);
    wait_results_drained();
    configure(65535, 65535, 254, 65535);
    issue_command(0, 32'hA000_0000, 8'd7);
    issue_command(0, 32'hA000_FFFE, 8'd8);
    issue_command(0, 32'hA000_FFFF, 8'd9);
    issue_command(0, 32'hA001_FFFF, 8'd11);
    wait_results_drained();
  endtask

  task automatic test_count_saturation();
    logic [31:0] base;
    base = $urandom();
    configure(0, 65535, 1, 0);
    // keep piling commands into one window well past 255 counts
    for (int i = 0; i < 260; i++)
      issue_command(1, base + i, servo_angle[1] + 8'(1 + i % 50));
    wait_results_drained();
  endtask

  task automatic test_random_traffic();
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 53; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 53; end
        default: begin snd_idle_pct = 34; rcv_stall_pct = 34; end
      endcase
      configure($urandom_range(60), $urandom_range(200, 3000), $urandom_range(1, 8),
                $urandom_range(1500));
      traffic_ms = $urandom();
      random_commands(260);
      wait_results_drained();
    end
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    configure($urandom_range(40), $urandom_range(200, 2000), $urandom_range(1, 6),
              $urandom_range(800));
    rcv_stall_pct = 20;
    stall_left    = 300;
    random_commands(40);
    wait_results_drained();
    rcv_stall_pct = 0;
  endtask

  initial begin
    foreach (guard_ready[i]) begin
      guard_ready[i] = 1'b0;
      servo_angle[i] = '0;
      stamp_valid[i] = 1'b0;
      accept_ms[i]   = '0;
      window_ms[i]   = '0;
      lockout_ms[i]  = '0;
      window_hits[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_guard_rules();
    test_limit_extremes();
    test_count_saturation();
    test_random_traffic();
    test_backpressure();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("servo_command_rate_guard verification clean");
    end else begin
      $display("servo_command_rate_guard verification failed");
    end
    $finish;
  end

endmodule
